@@ hdl/vpa_pkg.sv @@
package vpa_pkg;

  localparam int unsigned MEMORY_UNITS = 1024;
  localparam int unsigned ADDR_W       = 10;
  localparam int unsigned SIZE_W       = 11;
  localparam int unsigned OWNER_W      = 16;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned IN_DATA_W    = OP_W + OWNER_W + SIZE_W;
  localparam int unsigned OUT_DATA_W   = 16;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RES_OK       = 2'd0,
    RES_NOFIT    = 2'd1,
    RES_NOTFOUND = 2'd2,
    RES_FULL     = 2'd3
  } res_e;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  typedef enum logic [3:0] {
    CS_INIT,
    CS_IDLE,
    CS_DECODE,
    CS_ASCAN,
    CS_AWRITE,
    CS_GSCAN,
    CS_GSHIFT,
    CS_RMERGE,
    CS_CLEAR,
    CS_OUT
  } ctl_state_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_INIT,
    PH_ASCAN,
    PH_AWRITE,
    PH_GSCAN,
    PH_GSHIFT,
    PH_RMERGE,
    PH_CLEAR
  } phase_e;

  typedef struct packed {
    logic               used;
    logic [SIZE_W-1:0]  size;
    logic [ADDR_W-1:0]  start;
  } part_ent_t;

  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic [ADDR_W-1:0]  start;
  } grant_ent_t;

  typedef struct packed {
    phase_e phase;
    logic   first;
    logic   capture;
    logic   res_we;
    res_e   res_code;
  } vpa_cmd_t;

  typedef struct packed {
    logic done;
    op_e  op;
    logic need_zero;
    logic grant_full;
    logic found;
    logic split;
    logic part_full;
    logic g_found;
    logic out_busy;
  } vpa_sts_t;

endpackage

@@ hdl/vpa_ram.sv @@
module vpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/vpa_ctrl.sv @@
module vpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  vpa_pkg::vpa_sts_t sts_i,
  output vpa_pkg::vpa_cmd_t cmd_o
);
  import vpa_pkg::*;

  ctl_state_e state_q, state_d;
  logic       first_q;
  res_e       code_q, code_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_INIT;
      first_q <= 1'b1;
      code_q  <= RES_OK;
    end else begin
      state_q <= state_d;
      first_q <= (state_d != state_q);
      code_q  <= code_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    code_d         = code_q;
    s_tready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.phase    = PH_IDLE;
    cmd_o.first    = first_q;
    cmd_o.res_code = code_q;
    unique case (state_q)
      CS_INIT: begin
        cmd_o.phase = PH_INIT;
        state_d     = CS_IDLE;
      end
      CS_IDLE: begin
        s_tready_o    = 1'b1;
        cmd_o.capture = s_tvalid_i;
        if (s_tvalid_i) begin
          state_d = CS_DECODE;
        end
      end
      CS_DECODE: begin
        code_d = RES_OK;
        unique case (sts_i.op)
          OP_ALLOC: begin
            if (sts_i.need_zero) begin
              code_d  = RES_NOFIT;
              state_d = CS_OUT;
            end else if (sts_i.grant_full) begin
              code_d  = RES_FULL;
              state_d = CS_OUT;
            end else begin
              state_d = CS_ASCAN;
            end
          end
          OP_RELEASE: state_d = CS_GSCAN;
          OP_CLEAR:   state_d = CS_CLEAR;
          default:    state_d = CS_OUT;
        endcase
      end
      CS_ASCAN: begin
        cmd_o.phase = PH_ASCAN;
        if (sts_i.done) begin
          if (!sts_i.found) begin
            code_d  = RES_NOFIT;
            state_d = CS_OUT;
          end else if (sts_i.split && sts_i.part_full) begin
            code_d  = RES_FULL;
            state_d = CS_OUT;
          end else begin
            state_d = CS_AWRITE;
          end
        end
      end
      CS_AWRITE: begin
        cmd_o.phase = PH_AWRITE;
        if (sts_i.done) begin
          state_d = CS_OUT;
        end
      end
      CS_GSCAN: begin
        cmd_o.phase = PH_GSCAN;
        if (sts_i.done) begin
          if (!sts_i.g_found) begin
            code_d  = RES_NOTFOUND;
            state_d = CS_OUT;
          end else begin
            state_d = CS_GSHIFT;
          end
        end
      end
      CS_GSHIFT: begin
        cmd_o.phase = PH_GSHIFT;
        if (sts_i.done) begin
          state_d = CS_RMERGE;
        end
      end
      CS_RMERGE: begin
        cmd_o.phase = PH_RMERGE;
        if (sts_i.done) begin
          state_d = CS_OUT;
        end
      end
      CS_CLEAR: begin
        cmd_o.phase = PH_CLEAR;
        state_d     = CS_OUT;
      end
      CS_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.res_we = 1'b1;
          state_d      = CS_IDLE;
        end
      end
      default: state_d = CS_INIT;
    endcase
  end

endmodule

@@ hdl/vpa_datapath.sv @@
module vpa_datapath #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  vpa_pkg::vpa_cmd_t                   cmd_i,
  output vpa_pkg::vpa_sts_t                   sts_o,
  input  logic [1:0]                          fit_policy_i,
  input  logic [vpa_pkg::IN_DATA_W-1:0]       in_data_i,
  input  logic                                m_tready_i,
  output logic                                m_tvalid_o,
  output logic [vpa_pkg::OUT_DATA_W-1:0]      m_tdata_o
);
  import vpa_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PW = $bits(part_ent_t);
  localparam int unsigned GW = $bits(grant_ent_t);

  // request
  op_e                op_q;
  logic [OWNER_W-1:0] owner_q;
  logic [SIZE_W-1:0]  need_q;

  // counts and scan pointers
  logic [CW-1:0] part_cnt_q, part_cnt_d, grant_cnt_q, grant_cnt_d;
  logic [CW-1:0] rp_q, rp_d, wp_q, wp_d, limit;
  logic          rv_q, rv_d;
  logic [IW-1:0] ri_q, ri_d;
  logic          scan, done;

  // search results and carry registers
  logic              found_q, found_d, g_found_q, g_found_d, acc_v_q, acc_v_d;
  logic [IW-1:0]     pick_idx_q, pick_idx_d, g_idx_q, g_idx_d;
  logic [ADDR_W-1:0] pick_start_q, pick_start_d, g_start_q, g_start_d;
  logic [SIZE_W-1:0] pick_size_q, pick_size_d;
  part_ent_t         pend_q, pend_d, acc_q, acc_d, cur;
  logic [SIZE_W-1:0] acc_end, split_start;

  // memories
  logic          p_we, g_we;
  logic [IW-1:0] p_waddr, g_waddr;
  part_ent_t     p_wdata, p_rd;
  grant_ent_t    g_wdata, g_rd;
  logic [PW-1:0] p_rdata;
  logic [GW-1:0] g_rdata;

  // result register
  logic              m_valid_q;
  res_e              m_status_q;
  logic [ADDR_W-1:0] m_start_q;

  vpa_ram #(.WIDTH(PW), .DEPTH(TABLE_DEPTH)) u_part_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (rp_q[IW-1:0]),
    .rdata_o (p_rdata)
  );

  vpa_ram #(.WIDTH(GW), .DEPTH(TABLE_DEPTH)) u_grant_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .raddr_i (rp_q[IW-1:0]),
    .rdata_o (g_rdata)
  );

  assign p_rd        = part_ent_t'(p_rdata);
  assign g_rd        = grant_ent_t'(g_rdata);
  assign acc_end     = SIZE_W'(acc_q.start) + acc_q.size;
  assign split_start = SIZE_W'(pick_start_q) + need_q;

  always_comb begin
    unique case (cmd_i.phase)
      PH_ASCAN, PH_AWRITE, PH_RMERGE: limit = part_cnt_q;
      PH_GSCAN, PH_GSHIFT:            limit = grant_cnt_q;
      default:                        limit = '0;
    endcase
  end

  assign scan = (cmd_i.phase == PH_ASCAN) || (cmd_i.phase == PH_AWRITE) ||
                (cmd_i.phase == PH_RMERGE) || (cmd_i.phase == PH_GSCAN) ||
                (cmd_i.phase == PH_GSHIFT);
  assign done = !cmd_i.first && !rv_q && (rp_q >= limit);

  always_comb begin
    rp_d         = rp_q;
    rv_d         = 1'b0;
    ri_d         = ri_q;
    wp_d         = wp_q;
    part_cnt_d   = part_cnt_q;
    grant_cnt_d  = grant_cnt_q;
    found_d      = found_q;
    pick_idx_d   = pick_idx_q;
    pick_start_d = pick_start_q;
    pick_size_d  = pick_size_q;
    g_found_d    = g_found_q;
    g_idx_d      = g_idx_q;
    g_start_d    = g_start_q;
    pend_d       = pend_q;
    acc_d        = acc_q;
    acc_v_d      = acc_v_q;
    cur          = p_rd;
    p_we         = 1'b0;
    p_waddr      = '0;
    p_wdata      = '0;
    g_we         = 1'b0;
    g_waddr      = '0;
    g_wdata      = '0;

    if (scan && !cmd_i.first && (rp_q < limit)) begin
      rp_d = rp_q + 1'b1;
      rv_d = 1'b1;
      ri_d = rp_q[IW-1:0];
    end

    unique case (cmd_i.phase)
      PH_INIT, PH_CLEAR: begin
        p_we        = 1'b1;
        p_wdata     = '{used: 1'b0, size: SIZE_W'(MEMORY_UNITS), start: '0};
        part_cnt_d  = CW'(1);
        grant_cnt_d = '0;
      end
      PH_ASCAN: begin
        if (cmd_i.first) begin
          rp_d    = '0;
          found_d = 1'b0;
        end else if (rv_q && !p_rd.used && (p_rd.size >= need_q)) begin
          if (!found_q ||
              ((fit_policy_i == POL_BEST) && (p_rd.size < pick_size_q)) ||
              ((fit_policy_i == POL_WORST) && (p_rd.size > pick_size_q))) begin
            found_d      = 1'b1;
            pick_idx_d   = ri_q;
            pick_start_d = p_rd.start;
            pick_size_d  = p_rd.size;
          end
        end
      end
      PH_AWRITE: begin
        if (cmd_i.first) begin
          // claim the chosen partition, log the grant, carry the remainder
          p_we    = 1'b1;
          p_waddr = pick_idx_q;
          p_wdata = '{used: 1'b1, size: need_q, start: pick_start_q};
          g_we    = 1'b1;
          g_waddr = grant_cnt_q[IW-1:0];
          g_wdata = '{owner: owner_q, start: pick_start_q};
          pend_d  = '{used: 1'b0, size: pick_size_q - need_q,
                      start: split_start[ADDR_W-1:0]};
          wp_d    = CW'(pick_idx_q) + 1'b1;
          rp_d    = sts_o.split ? (CW'(pick_idx_q) + 1'b1) : part_cnt_q;
        end else if (rv_q) begin
          p_we    = 1'b1;
          p_waddr = wp_q[IW-1:0];
          p_wdata = pend_q;
          pend_d  = p_rd;
          wp_d    = wp_q + 1'b1;
        end else if (done) begin
          if (sts_o.split) begin
            p_we       = 1'b1;
            p_waddr    = wp_q[IW-1:0];
            p_wdata    = pend_q;
            part_cnt_d = part_cnt_q + 1'b1;
          end
          grant_cnt_d = grant_cnt_q + 1'b1;
        end
      end
      PH_GSCAN: begin
        if (cmd_i.first) begin
          rp_d      = '0;
          g_found_d = 1'b0;
        end else if (rv_q && !g_found_q && (g_rd.owner == owner_q)) begin
          g_found_d = 1'b1;
          g_idx_d   = ri_q;
          g_start_d = g_rd.start;
        end
      end
      PH_GSHIFT: begin
        if (cmd_i.first) begin
          rp_d = CW'(g_idx_q) + 1'b1;
          wp_d = CW'(g_idx_q);
        end else if (rv_q) begin
          g_we    = 1'b1;
          g_waddr = wp_q[IW-1:0];
          g_wdata = g_rd;
          wp_d    = wp_q + 1'b1;
        end else if (done) begin
          grant_cnt_d = grant_cnt_q - 1'b1;
        end
      end
      PH_RMERGE: begin
        if (cmd_i.first) begin
          rp_d    = '0;
          wp_d    = '0;
          acc_v_d = 1'b0;
        end else if (rv_q) begin
          // free the released partition, fold free neighbors into the accumulator
          if (p_rd.start == g_start_q) begin
            cur.used = 1'b0;
          end
          if (!acc_v_q) begin
            acc_d   = cur;
            acc_v_d = 1'b1;
          end else if (!acc_q.used && !cur.used &&
                       (acc_end == SIZE_W'(cur.start))) begin
            acc_d.size = acc_q.size + cur.size;
          end else begin
            p_we    = 1'b1;
            p_waddr = wp_q[IW-1:0];
            p_wdata = acc_q;
            wp_d    = wp_q + 1'b1;
            acc_d   = cur;
          end
        end else if (done) begin
          p_we       = 1'b1;
          p_waddr    = wp_q[IW-1:0];
          p_wdata    = acc_q;
          part_cnt_d = wp_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q        <= 1'b0;
      part_cnt_q  <= CW'(1);
      grant_cnt_q <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      rv_q        <= rv_d;
      part_cnt_q  <= part_cnt_d;
      grant_cnt_q <= grant_cnt_d;
      if (cmd_i.res_we) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q         <= rp_d;
    ri_q         <= ri_d;
    wp_q         <= wp_d;
    found_q      <= found_d;
    pick_idx_q   <= pick_idx_d;
    pick_start_q <= pick_start_d;
    pick_size_q  <= pick_size_d;
    g_found_q    <= g_found_d;
    g_idx_q      <= g_idx_d;
    g_start_q    <= g_start_d;
    pend_q       <= pend_d;
    acc_q        <= acc_d;
    acc_v_q      <= acc_v_d;
    if (cmd_i.capture) begin
      op_q    <= op_e'(in_data_i[OP_W-1:0]);
      owner_q <= in_data_i[OP_W+OWNER_W-1:OP_W];
      need_q  <= in_data_i[IN_DATA_W-1:OP_W+OWNER_W];
    end
    if (cmd_i.res_we) begin
      m_status_q <= cmd_i.res_code;
      m_start_q  <= ((cmd_i.res_code == RES_OK) && (op_q == OP_ALLOC)) ?
                    pick_start_q : '0;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.done       = done;
    sts_o.op         = op_q;
    sts_o.need_zero  = (need_q == '0);
    sts_o.grant_full = (grant_cnt_q >= CW'(TABLE_DEPTH));
    sts_o.found      = found_q;
    sts_o.split      = (pick_size_q > need_q);
    sts_o.part_full  = (part_cnt_q >= CW'(TABLE_DEPTH));
    sts_o.g_found    = g_found_q;
    sts_o.out_busy   = m_valid_q && !m_tready_i;
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {{(OUT_DATA_W - ADDR_W - 2){1'b0}}, m_start_q, m_status_q};

endmodule

@@ hdl/variable_partition_allocator.sv @@
// Variable-partition allocator. Keeps an address-ordered table of partitions
// covering MEMORY_UNITS units and a list of grants in the order they were made.
// An allocate item picks a free partition by first, best or worst fit (ties to
// the lowest index, fit_policy 3 acts as first fit), splits off the remainder
// and returns the start; a release item frees the oldest grant of its owner and
// merges free neighbors; a clear item restores one free partition. Each item
// gives exactly one result item: status (0 ok, 1 no fit or size zero, 2 owner
// not found, 3 table full) and granted_start (zero unless an allocate succeeds).
// Items are handled one at a time; both tables sit in single-port-read RAMs
// that are walked one entry per cycle, which sets the latency. An allocate
// runs a search pass, then, if it fits, a pass that shifts the entries after
// the split; a release runs an owner search, a grant list shift and a merge
// pass; a clear, the reserved opcode and a rejected size-zero allocate run no
// pass. After reset the block seeds the partition table before it takes its
// first item. A new item is taken while the previous result still waits on
// the output register; its own result then holds in the output state until
// the output register is free.
// Write fit_policy through the APB port only while the block is idle.
module variable_partition_allocator #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [1:0] opcode, [17:2] owner_id, [28:18] request_size
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [1:0] status, [11:2] granted_start
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vpa_pkg::*;

  logic [1:0] fit_policy_q;
  vpa_cmd_t   cmd;
  vpa_sts_t   sts;

  // Single register at byte address 0; writes land on the access phase.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {30'd0, fit_policy_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_policy_q <= POL_FIRST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      fit_policy_q <= pwdata[1:0];
    end
  end

  // Sequence the passes; the datapath owns the tables and the counters.
  vpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vpa_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .fit_policy_i (fit_policy_q),
    .in_data_i    (s_axis_tdata[IN_DATA_W-1:0]),
    .m_tready_i   (m_axis_tready),
    .m_tvalid_o   (m_axis_tvalid),
    .m_tdata_o    (m_axis_tdata)
  );

endmodule
